/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl core
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked on every edge out of reset
`define KAL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked on every edge, reset included
`define KAL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define KAL_ASSERT(lbl, prop, msg)
`define KAL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/core/msk_pkg.sv */
// package for the multichannel scalar kalman filter
// fixed-point widths, reset values and register indexes; no dependencies
package msk_pkg;

    // field widths
    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 16;
    localparam int EST_W    = 24;
    localparam int GAIN_W   = 16;
    localparam int ERR_W    = 24;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_ERROR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 1'b1;

    // reset values, Q8.16
    localparam logic [ERR_W-1:0] ONE_Q16          = 24'd65536;
    localparam logic [ERR_W-1:0] MEASURE_ERR_INIT = 24'd65536;
    localparam logic [ERR_W-1:0] PROC_NOISE_INIT  = 24'd655;
    localparam logic [ERR_W-1:0] ERR_MAX          = 24'hFFFFFF;

    // number of quotient bits for the gain divide
    localparam int DIV_STEPS = 17;

endpackage

/* rtl/core/multichannel_scalar_kalman.sv */
// multichannel scalar kalman filter, top level
// uses msk_pkg and assert_macros.svh
//
// Each accepted word carries a channel and a 16-bit sample and yields one result word with
// the new estimate (Q16.8), the gain used (Q0.16) and the new error (Q8.16). The work runs on
// one shared datapath under a small sequencer: a load step, a restoring divide for the gain
// (skipped when the denominator is zero), three passes through a single 24x24 multiplier and
// a finishing step; a channel out of range goes from the load step straight to finishing.
// The result word reaches the output register in the same cycle that in_ready rises.
// in_ready is high only while the sequencer is idle, so no word is taken before the last
// one has finished; a finished result sits in the output register, so the next word can be
// taken while it waits, and that next word then holds in its finishing state until the
// waiting result is taken. Configuration writes are taken at once and are meant to happen
// only while the block is idle.
`include "assert_macros.svh"

module multichannel_scalar_kalman #(
    parameter int NUM_CHANNELS = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [msk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msk_pkg::ERR_W-1:0]       cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [msk_pkg::CH_W-1:0]        channel,
    input  logic [msk_pkg::SAMPLE_W-1:0]    sample,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [msk_pkg::CH_W-1:0]        channel_out,
    output logic [msk_pkg::EST_W-1:0]       estimate,
    output logic [msk_pkg::GAIN_W-1:0]      gain,
    output logic [msk_pkg::ERR_W-1:0]       error_estimate
);
    import msk_pkg::*;

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LD   = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_M1   = 3'd3;
    localparam logic [2:0] S_M2   = 3'd4;
    localparam logic [2:0] S_M3   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    // configuration and per-channel state
    logic [ERR_W-1:0] meas_err_reg;
    logic [ERR_W-1:0] proc_noise_reg;
    logic [EST_W-1:0] last_est_reg [NUM_CHANNELS];
    logic [ERR_W-1:0] est_err_reg  [NUM_CHANNELS];

    // sequencer and datapath registers
    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [SAMPLE_W-1:0] smp_reg;
    logic                oor_reg;
    logic [ERR_W-1:0]    err_reg;
    logic [EST_W-1:0]    last_reg;
    logic [ERR_W:0]      denom_reg;
    logic [EST_W-1:0]    absd_reg;
    logic                neg_reg;
    logic [ERR_W:0]      rem_reg;
    logic [DIV_STEPS-1:0] sh_reg;
    logic [DIV_STEPS-1:0] quo_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [47:0]         prod_reg;
    logic [EST_W-1:0]    mag_reg;
    logic [ERR_W-1:0]    t1_reg;

    // output register
    logic                out_valid_reg;
    logic [CH_W-1:0]     ch_out_reg;
    logic [EST_W-1:0]    est_out_reg;
    logic [GAIN_W-1:0]   gain_out_reg;
    logic [ERR_W-1:0]    err_out_reg;

    // combinational helpers
    logic [ERR_W-1:0]    err_sel;
    logic [EST_W-1:0]    last_sel;
    logic [ERR_W:0]      denom_w;
    logic [EST_W-1:0]    target_w;
    logic [ERR_W+1:0]    trial_w;
    logic                ge_w;
    logic [GAIN_W-1:0]   gain_w;
    logic [23:0]         mul_a;
    logic [23:0]         mul_b;
    logic [EST_W-1:0]    est_w;
    logic [40:0]         nerr_sum_w;
    logic [ERR_W-1:0]    nerr_w;
    logic                accept_w;
    logic                out_free_w;
    logic                write_w;

    assign accept_w   = in_valid && in_ready;
    assign out_free_w = !out_valid_reg || out_ready;
    assign write_w    = (state_reg == S_FIN) && out_free_w && !oor_reg;

    // channel select from the state arrays
    always_comb
    begin
        err_sel  = '0;
        last_sel = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (5'(ch_reg) == 5'(i))
            begin
                err_sel  = est_err_reg[i];
                last_sel = last_est_reg[i];
            end
        end
    end

    assign denom_w  = {1'b0, err_sel} + {1'b0, meas_err_reg};
    assign target_w = {smp_reg, 8'd0};

    // one restoring divide step
    assign trial_w = {rem_reg, sh_reg[DIV_STEPS-1]};
    assign ge_w    = trial_w >= {1'b0, denom_reg};
    assign gain_w  = quo_reg[DIV_STEPS-1] ? {GAIN_W{1'b1}} : quo_reg[GAIN_W-1:0];

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_M1:
            begin
                mul_a = {8'd0, gain_w};
                mul_b = absd_reg;
            end
            S_M2:
            begin
                mul_a = ONE_Q16 - {8'd0, gain_reg};
                mul_b = err_reg;
            end
            S_M3:
            begin
                mul_a = mag_reg;
                mul_b = proc_noise_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // final estimate and saturated error
    assign est_w      = neg_reg ? (last_reg - mag_reg) : (last_reg + mag_reg);
    assign nerr_sum_w = {17'd0, t1_reg} + {1'b0, prod_reg[47:8]};
    assign nerr_w     = (nerr_sum_w > {17'd0, ERR_MAX}) ? ERR_MAX : nerr_sum_w[ERR_W-1:0];

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept_w)
                    state_next = S_LD;
            end
            S_LD:
            begin
                if (oor_reg)
                    state_next = S_FIN;
                else if (denom_w == '0)
                    state_next = S_M1;
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = S_M1;
            end
            S_M1:    state_next = S_M2;
            S_M2:    state_next = S_M3;
            S_M3:    state_next = S_FIN;
            S_FIN:
            begin
                if (out_free_w)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            meas_err_reg   <= MEASURE_ERR_INIT;
            proc_noise_reg <= PROC_NOISE_INIT;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                last_est_reg[i] <= '0;
                est_err_reg[i]  <= ONE_Q16;
            end
        end
        else
        begin
            state_reg <= state_next;

            // divide step counter
            if (state_reg == S_DIV)
                cnt_reg <= cnt_reg + 1'b1;
            else
                cnt_reg <= '0;

            // output handshake
            if (state_reg == S_FIN && out_free_w)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MEASURE_ERROR: meas_err_reg   <= cfg_wdata;
                    REG_PROCESS_NOISE: proc_noise_reg <= cfg_wdata;
                    default:           ;
                endcase
            end

            // channel state update
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (write_w && 5'(ch_reg) == 5'(i))
                begin
                    last_est_reg[i] <= est_w;
                    est_err_reg[i]  <= nerr_w;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept_w)
                begin
                    ch_reg  <= channel;
                    smp_reg <= sample;
                    oor_reg <= 5'(channel) >= 5'(NUM_CHANNELS);
                end
            end
            S_LD:
            begin
                err_reg   <= err_sel;
                last_reg  <= last_sel;
                denom_reg <= denom_w;
                neg_reg   <= target_w < last_sel;
                absd_reg  <= (target_w < last_sel) ? (last_sel - target_w)
                                                   : (target_w - last_sel);
                rem_reg   <= {2'b00, err_sel[ERR_W-1:1]};
                sh_reg    <= {err_sel[0], 16'd0};
                quo_reg   <= '0;
            end
            S_DIV:
            begin
                rem_reg <= ge_w ? 25'(trial_w - {1'b0, denom_reg}) : trial_w[ERR_W:0];
                sh_reg  <= {sh_reg[DIV_STEPS-2:0], 1'b0};
                quo_reg <= {quo_reg[DIV_STEPS-2:0], ge_w};
            end
            S_M1:
            begin
                gain_reg <= gain_w;
                prod_reg <= mul_a * mul_b;
            end
            S_M2:
            begin
                mag_reg  <= prod_reg[39:16];
                prod_reg <= mul_a * mul_b;
            end
            S_M3:
            begin
                t1_reg   <= prod_reg[39:16];
                prod_reg <= mul_a * mul_b;
            end
            S_FIN:
            begin
                if (out_free_w)
                begin
                    ch_out_reg   <= ch_reg;
                    est_out_reg  <= oor_reg ? '0 : est_w;
                    gain_out_reg <= oor_reg ? '0 : gain_reg;
                    err_out_reg  <= oor_reg ? '0 : nerr_w;
                end
            end
            default: ;
        endcase
    end

    // ports
    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign channel_out    = ch_out_reg;
    assign estimate       = est_out_reg;
    assign gain           = gain_out_reg;
    assign error_estimate = err_out_reg;

    // checks
    `KAL_ASSERT_ALWAYS(a_cnt_range, cnt_reg <= CNT_W'(DIV_STEPS), "divide counter out of range")
    `KAL_ASSERT(a_accept_load, accept_w |=> state_reg == S_LD, "accepted word not loaded")
    `KAL_ASSERT(a_rem_below, state_reg == S_DIV |-> rem_reg < denom_reg, "remainder not below divisor")
    `KAL_ASSERT(a_zero_denom, (state_reg == S_M1 && denom_reg == '0) |-> gain_w == '0, "gain nonzero on zero denominator")
    `KAL_ASSERT(a_oor_zero, (out_valid && 5'(channel_out) >= 5'(NUM_CHANNELS)) |-> (estimate == '0 && gain == '0 && error_estimate == '0), "bad channel result not zero")

endmodule

/* verif/tb_multichannel_scalar_kalman.sv */
// self-checking testbench for the multichannel scalar kalman filter
// depends on msk_pkg and multichannel_scalar_kalman; per-channel predictor kept in the bench

module tb_multichannel_scalar_kalman;

    timeunit 1ns;
    timeprecision 1ps;

    import msk_pkg::*;

    localparam int          CHANNELS    = 6;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          SETTLE      = 30;

    // one result word as seen on the output side
    typedef struct packed {
        logic [CH_W-1:0]   chan;
        logic [EST_W-1:0]  est;
        logic [GAIN_W-1:0] gain;
        logic [ERR_W-1:0]  err;
    } kal_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ERR_W-1:0]     cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    logic [CH_W-1:0]      channel;
    logic [SAMPLE_W-1:0]  sample;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [CH_W-1:0]      channel_out;
    logic [EST_W-1:0]     estimate;
    logic [GAIN_W-1:0]    gain;
    logic [ERR_W-1:0]     error_estimate;

    // filter state mirrored in the bench
    logic [EST_W-1:0] chan_estimate [CHANNELS];
    logic [ERR_W-1:0] chan_error    [CHANNELS];
    logic [ERR_W-1:0] cfg_measure_error;
    logic [ERR_W-1:0] cfg_process_noise;

    kal_word_t   pending_results [$];
    kal_word_t   oldest_result;
    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          no_idle;

    multichannel_scalar_kalman #(
        .NUM_CHANNELS (CHANNELS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .channel        (channel),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .channel_out    (channel_out),
        .estimate       (estimate),
        .gain           (gain),
        .error_estimate (error_estimate)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            cycle_count <= cycle_count + 1;
    end

    // receiver backpressure about 20 percent of the time, off while no_idle is set
    always @(posedge clk)
    begin
        out_ready <= no_idle || ($urandom_range(99) >= 20);
    end

    // one filter update for an accepted word; advances the mirrored state
    function automatic kal_word_t kalman_update(input logic [CH_W-1:0] ch,
                                                input logic [SAMPLE_W-1:0] smp);
        kal_word_t       r;
        longint unsigned err_q;
        longint unsigned last_q;
        longint unsigned denom;
        longint unsigned g;
        longint unsigned target;
        longint unsigned mag;
        longint unsigned est_q;
        longint unsigned nerr;
        r.chan = ch;
        if (ch >= CHANNELS)
        begin
            // channel out of range: zeros, state untouched
            r.est  = '0;
            r.gain = '0;
            r.err  = '0;
            return r;
        end
        err_q  = 64'(chan_error[ch]);
        last_q = 64'(chan_estimate[ch]);
        denom  = err_q + 64'(cfg_measure_error);
        // gain, zero on an empty denominator, clipped below 1.0
        if (denom == 0)
            g = 0;
        else
        begin
            g = (err_q << 16) / denom;
            if (g > 64'hFFFF)
                g = 64'hFFFF;
        end
        // move toward the sample
        target = 64'(smp) << 8;
        if (target >= last_q)
        begin
            mag   = (g * (target - last_q)) >> 16;
            est_q = last_q + mag;
        end
        else
        begin
            mag   = (g * (last_q - target)) >> 16;
            est_q = last_q - mag;
        end
        est_q &= 64'hFFFFFF;
        // error update with saturation
        nerr = (((64'd65536 - g) * err_q) >> 16) + ((mag * 64'(cfg_process_noise)) >> 8);
        if (nerr > 64'hFFFFFF)
            nerr = 64'hFFFFFF;
        chan_estimate[ch] = est_q[EST_W-1:0];
        chan_error[ch]    = nerr[ERR_W-1:0];
        r.est  = est_q[EST_W-1:0];
        r.gain = g[GAIN_W-1:0];
        r.err  = nerr[ERR_W-1:0];
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with none expected, channel_out %0d", channel_out);
                mismatch_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (channel_out !== oldest_result.chan)
                begin
                    $error("channel_out expected %0d actual %0d",
                           oldest_result.chan, channel_out);
                    mismatch_count++;
                end
                if (estimate !== oldest_result.est)
                begin
                    $error("estimate expected %0d actual %0d", oldest_result.est, estimate);
                    mismatch_count++;
                end
                if (gain !== oldest_result.gain)
                begin
                    $error("gain expected %0d actual %0d", oldest_result.gain, gain);
                    mismatch_count++;
                end
                if (error_estimate !== oldest_result.err)
                begin
                    $error("error_estimate expected %0d actual %0d",
                           oldest_result.err, error_estimate);
                    mismatch_count++;
                end
            end
        end
    end

    // send one input word, with a random gap in front of it unless no_idle is set
    task automatic send_word(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
        while (!no_idle && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        channel  <= ch;
        sample   <= smp;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        pending_results.push_back(kalman_update(ch, smp));
    endtask

    // hold off input until every result is back and the sequencer has settled
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // register write, only while idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ERR_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MEASURE_ERROR)
            cfg_measure_error = val;
        else if (idx == REG_PROCESS_NOISE)
            cfg_process_noise = val;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [ERR_W-1:0] meas, input logic [ERR_W-1:0] noise);
        drain();
        write_reg(REG_MEASURE_ERROR, meas);
        write_reg(REG_PROCESS_NOISE, noise);
    endtask

    // every channel once from reset values, plus both out-of-range codes
    task automatic test_channels_from_reset;
        send_word(3'd0, 16'd0);
        send_word(3'd1, 16'hFFFF);
        send_word(3'd2, 16'd1000);
        send_word(3'd3, 16'd1);
        send_word(3'd4, 16'h8000);
        send_word(3'd5, 16'h7FFF);
        send_word(3'd6, 16'h5555);
        send_word(3'd7, 16'hAAAA);
    endtask

    // sample extremes back to back on channel 0, both directions of change, then one on channel 1
    task automatic test_sample_extremes;
        send_word(3'd0, 16'hFFFF);
        send_word(3'd0, 16'd0);
        send_word(3'd0, 16'hFFFF);
        send_word(3'd0, 16'hFFFF);
        send_word(3'd1, 16'd0);
    endtask

    // zero measurement error: gain clips at one, error decays to zero,
    // then the denominator is empty and the state holds
    task automatic test_zero_denominator;
        set_config(24'd0, 24'd0);
        send_word(3'd2, 16'd500);
        send_word(3'd2, 16'd900);
        send_word(3'd2, 16'd100);
        send_word(3'd2, 16'hFFFF);
        send_word(3'd4, 16'd0);
    endtask

    // large noise factor drives the error to saturation
    task automatic test_error_saturation;
        set_config(24'hFFFFFF, 24'hFFFFFF);
        send_word(3'd3, 16'hFFFF);
        send_word(3'd3, 16'd0);
        send_word(3'd3, 16'hFFFF);
        send_word(3'd5, 16'd0);
    endtask

    // random words over several register settings
    task automatic test_random_settings;
        logic [ERR_W-1:0]    meas;
        logic [ERR_W-1:0]    noise;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] smp;
        int                  near_val;
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: begin meas = MEASURE_ERR_INIT; noise = PROC_NOISE_INIT; end
                1: begin meas = '0; noise = '0; end
                2: begin meas = ERR_MAX; noise = ERR_MAX; end
                3: begin meas = 24'd1; noise = 24'd65536; end
                4:
                begin
                    meas  = 24'($urandom_range(0, 24'hFFFFFF));
                    noise = 24'($urandom_range(0, 24'hFFFFFF));
                end
                5:
                begin
                    meas  = 24'($urandom_range(0, 131072));
                    noise = 24'($urandom_range(0, 4096));
                end
                default:
                begin
                    meas  = 24'($urandom_range(0, 24'hFFFFFF));
                    noise = 24'($urandom_range(0, 1024));
                end
            endcase
            set_config(meas, noise);
            // one phase runs with neither side idling
            no_idle = (ph == 5);
            for (int k = 0; k < 92; k++)
            begin
                if ($urandom_range(99) < 8)
                    ch = 3'(6 + $urandom_range(1));
                else
                    ch = 3'($urandom_range(CHANNELS - 1));
                case ($urandom_range(9))
                    0: smp = 16'd0;
                    1: smp = 16'hFFFF;
                    2, 3, 4:
                    begin
                        // small step around the current estimate
                        near_val = (ch < CHANNELS) ? int'(chan_estimate[ch] >> 8) : 0;
                        near_val = near_val + $urandom_range(128) - 64;
                        if (near_val < 0)
                            near_val = 0;
                        if (near_val > 65535)
                            near_val = 65535;
                        smp = 16'(near_val);
                    end
                    default: smp = 16'($urandom);
                endcase
                send_word(ch, smp);
            end
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        no_idle           = 1'b0;
        cfg_measure_error = MEASURE_ERR_INIT;
        cfg_process_noise = PROC_NOISE_INIT;
        for (int i = 0; i < CHANNELS; i++)
        begin
            chan_estimate[i] = '0;
            chan_error[i]    = ONE_Q16;
        end
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        channel   <= '0;
        sample    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_channels_from_reset();
        test_sample_extremes();
        test_zero_denominator();
        test_error_saturation();
        test_random_settings();

        // wait out the last results
        drain();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
